// ----- rtl/core/tbc_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the triangle barycentric coordinate block.
// No dependencies.
package tbc_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS = 24;
  localparam int OUT_W = 32;
  localparam int QUEUE_DEPTH = 2;

endpackage

// ----- rtl/core/tbc_mul.sv -----
`timescale 1ns / 1ps
// Two-stage signed multiplier built from four half-width partial products.
// No dependencies.
module tbc_mul #(
  parameter int AW = 35
) (
  input  logic                  clk,
  input  logic signed [AW-1:0]  a,
  input  logic signed [AW-1:0]  b,
  output logic signed [2*AW-1:0] p
);

  localparam int H = AW / 2;
  localparam int HW = AW - H;
  localparam int P = 2 * AW;

  logic signed [HW-1:0] ah, bh;
  logic [H-1:0] al, bl;
  logic signed [2*HW-1:0] pp_hh;
  logic signed [HW+H:0] pp_hl, pp_lh;
  logic [2*H-1:0] pp_ll;

  assign ah = a[AW-1:H];
  assign bh = b[AW-1:H];
  assign al = a[H-1:0];
  assign bl = b[H-1:0];

  always_ff @(posedge clk) begin
    pp_hh <= ah * bh;
    pp_hl <= ah * $signed({1'b0, bl});
    pp_lh <= bh * $signed({1'b0, al});
    pp_ll <= al * bl;
  end

  always_ff @(posedge clk) begin
    p <= (P'(pp_hh) <<< (2 * H)) + (P'(pp_hl) <<< H) + (P'(pp_lh) <<< H)
         + P'($signed({1'b0, pp_ll}));
  end

endmodule

// ----- rtl/core/tbc_front.sv -----
`timescale 1ns / 1ps
// Front part: edge vectors, cross products, dot products and divider operands.
// Depends on tbc_pkg and tbc_mul.
module tbc_front #(
  parameter int CB = tbc_pkg::COORD_BITS_DEF,
  parameter int FW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [CB-1:0] v0_x,
  input  logic signed [CB-1:0] v0_y,
  input  logic signed [CB-1:0] v0_z,
  input  logic signed [CB-1:0] v1_x,
  input  logic signed [CB-1:0] v1_y,
  input  logic signed [CB-1:0] v1_z,
  input  logic signed [CB-1:0] v2_x,
  input  logic signed [CB-1:0] v2_y,
  input  logic signed [CB-1:0] v2_z,
  input  logic signed [CB-1:0] p_x,
  input  logic signed [CB-1:0] p_y,
  input  logic signed [CB-1:0] p_z,
  output logic                 out_valid,
  output logic [FW-1:0]        out_data
);

  localparam int FB = tbc_pkg::FRAC_BITS;
  localparam int DW = CB + 1;
  localparam int CW = 2 * DW + 1;
  localparam int PW = 2 * CW + 2;
  localparam int QW = PW + FB;

  logic [7:0] vld;
  logic signed [DW-1:0] e1 [3];
  logic signed [DW-1:0] e2 [3];
  logic signed [DW-1:0] e3 [3];
  logic signed [DW-1:0] e4 [3];
  logic signed [DW-1:0] e5 [3];
  logic signed [2*DW-1:0] pn_p [3];
  logic signed [2*DW-1:0] pn_m [3];
  logic signed [2*DW-1:0] pa_p [3];
  logic signed [2*DW-1:0] pa_m [3];
  logic signed [2*DW-1:0] pb_p [3];
  logic signed [2*DW-1:0] pb_m [3];
  logic signed [CW-1:0] n [3];
  logic signed [CW-1:0] a0 [3];
  logic signed [CW-1:0] a1 [3];
  logic signed [2*CW-1:0] mn [3];
  logic signed [2*CW-1:0] ma [3];
  logic signed [2*CW-1:0] mb [3];
  logic signed [PW-1:0] nn, da, db;
  logic [PW-1:0] nn_s7, abs_a, abs_b;
  logic nz_s7, nega_s7, negb_s7;
  logic [QW-1:0] num_a, num_b;
  logic [PW-1:0] nn_s8;
  logic nz_s8, nega_s8, negb_s8;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[6:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    e1[0] <= DW'(v1_x) - DW'(v0_x);
    e1[1] <= DW'(v1_y) - DW'(v0_y);
    e1[2] <= DW'(v1_z) - DW'(v0_z);
    e2[0] <= DW'(v2_x) - DW'(v0_x);
    e2[1] <= DW'(v2_y) - DW'(v0_y);
    e2[2] <= DW'(v2_z) - DW'(v0_z);
    e3[0] <= DW'(v0_x) - DW'(p_x);
    e3[1] <= DW'(v0_y) - DW'(p_y);
    e3[2] <= DW'(v0_z) - DW'(p_z);
    e4[0] <= DW'(v1_x) - DW'(p_x);
    e4[1] <= DW'(v1_y) - DW'(p_y);
    e4[2] <= DW'(v1_z) - DW'(p_z);
    e5[0] <= DW'(v2_x) - DW'(p_x);
    e5[1] <= DW'(v2_y) - DW'(p_y);
    e5[2] <= DW'(v2_z) - DW'(p_z);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pn_p[k] <= e1[(k + 1) % 3] * e2[(k + 2) % 3];
      pn_m[k] <= e1[(k + 2) % 3] * e2[(k + 1) % 3];
      pa_p[k] <= e4[(k + 1) % 3] * e5[(k + 2) % 3];
      pa_m[k] <= e4[(k + 2) % 3] * e5[(k + 1) % 3];
      pb_p[k] <= e5[(k + 1) % 3] * e3[(k + 2) % 3];
      pb_m[k] <= e5[(k + 2) % 3] * e3[(k + 1) % 3];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      n[k] <= CW'(pn_p[k]) - CW'(pn_m[k]);
      a0[k] <= CW'(pa_p[k]) - CW'(pa_m[k]);
      a1[k] <= CW'(pb_p[k]) - CW'(pb_m[k]);
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_dot
    tbc_mul #(.AW(CW)) u_mn (.clk(clk), .a(n[g]), .b(n[g]), .p(mn[g]));
    tbc_mul #(.AW(CW)) u_ma (.clk(clk), .a(a0[g]), .b(n[g]), .p(ma[g]));
    tbc_mul #(.AW(CW)) u_mb (.clk(clk), .a(a1[g]), .b(n[g]), .p(mb[g]));
  end

  always_ff @(posedge clk) begin
    nn <= PW'(mn[0]) + PW'(mn[1]) + PW'(mn[2]);
    da <= PW'(ma[0]) + PW'(ma[1]) + PW'(ma[2]);
    db <= PW'(mb[0]) + PW'(mb[1]) + PW'(mb[2]);
  end

  always_ff @(posedge clk) begin
    nn_s7 <= nn;
    nz_s7 <= (nn != '0);
    nega_s7 <= da[PW-1];
    negb_s7 <= db[PW-1];
    abs_a <= da[PW-1] ? PW'(-da) : PW'(da);
    abs_b <= db[PW-1] ? PW'(-db) : PW'(db);
  end

  always_ff @(posedge clk) begin
    nn_s8 <= nn_s7;
    nz_s8 <= nz_s7;
    nega_s8 <= nega_s7;
    negb_s8 <= negb_s7;
    num_a <= {abs_a, {FB{1'b0}}} + QW'(nn_s7 >> 1);
    num_b <= {abs_b, {FB{1'b0}}} + QW'(nn_s7 >> 1);
  end

  assign out_valid = vld[7];
  assign out_data = {nz_s8, nega_s8, negb_s8, nn_s8, num_a, num_b};

endmodule

// ----- rtl/core/tbc_fifo.sv -----
`timescale 1ns / 1ps
// Short queue between the front and the back part, registered read side.
// Depends on tbc_pkg.
module tbc_fifo #(
  parameter int W = 8,
  parameter int DEPTH = tbc_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         pop_valid,
  output logic [W-1:0] pop_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0] mem [DEPTH];
  logic [IW-1:0] wr_ptr, rd_ptr;
  logic [CNTW-1:0] count;
  logic pop;

  assign pop = (count != '0);
  assign full = (count == CNTW'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    if (pop) begin
      pop_data <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
      pop_valid <= 1'b0;
    end else begin
      pop_valid <= pop;
      if (push) begin
        wr_ptr <= (wr_ptr == IW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNTW'(push) - CNTW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("Queue written while full.");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(DEPTH))
    else $error("Queue count out of range.");
  a_pop_follows: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |=> pop_valid)
    else $error("Queue did not drain a waiting beat.");

endmodule

// ----- rtl/core/tbc_back.sv -----
`timescale 1ns / 1ps
// Back part: pipelined restoring divider for both weights, sign, third weight
// and saturation. Depends on tbc_pkg.
module tbc_back #(
  parameter int CB = tbc_pkg::COORD_BITS_DEF,
  parameter int FW = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic [FW-1:0]                      in_data,
  output logic                               done,
  output logic signed [tbc_pkg::OUT_W-1:0]   bary_a,
  output logic signed [tbc_pkg::OUT_W-1:0]   bary_b,
  output logic signed [tbc_pkg::OUT_W-1:0]   bary_c,
  output logic                               valid_res
);

  localparam int FB = tbc_pkg::FRAC_BITS;
  localparam int OW = tbc_pkg::OUT_W;
  localparam int DW = CB + 1;
  localparam int CW = 2 * DW + 1;
  localparam int PW = 2 * CW + 2;
  localparam int QW = PW + FB;
  localparam int SW = QW + 1;
  localparam int XW = SW + 2;

  logic [QW:0] vld;
  logic nz [QW+1];
  logic nega [QW+1];
  logic negb [QW+1];
  logic [PW-1:0] den [QW+1];
  logic [PW-1:0] ra [QW+1];
  logic [PW-1:0] rb [QW+1];
  logic [QW-1:0] xa [QW+1];
  logic [QW-1:0] xb [QW+1];

  assign {nz[0], nega[0], negb[0], den[0], xa[0], xb[0]} = in_data;
  assign ra[0] = '0;
  assign rb[0] = '0;

  for (genvar s = 0; s < QW; s++) begin : g_div
    logic [PW:0] ta, tb;
    logic ge_a, ge_b;
    assign ta = {ra[s], xa[s][QW-1]};
    assign tb = {rb[s], xb[s][QW-1]};
    assign ge_a = (ta >= {1'b0, den[s]});
    assign ge_b = (tb >= {1'b0, den[s]});
    always_ff @(posedge clk) begin
      nz[s+1] <= nz[s];
      nega[s+1] <= nega[s];
      negb[s+1] <= negb[s];
      den[s+1] <= den[s];
      ra[s+1] <= ge_a ? PW'(ta - {1'b0, den[s]}) : PW'(ta);
      rb[s+1] <= ge_b ? PW'(tb - {1'b0, den[s]}) : PW'(tb);
      xa[s+1] <= {xa[s][QW-2:0], ge_a};
      xb[s+1] <= {xb[s][QW-2:0], ge_b};
    end
  end

  logic signed [SW-1:0] wa, wb;
  logic signed [XW-1:0] wa2, wb2, wc2;
  logic nz_t, nz_u;
  logic v_t;

  function automatic logic signed [OW-1:0] sat(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] hi_lim, lo_lim;
    hi_lim = XW'(signed'({1'b0, {(OW-1){1'b1}}}));
    lo_lim = -hi_lim - XW'(1);
    if (x > hi_lim) begin
      sat = {1'b0, {(OW-1){1'b1}}};
    end else if (x < lo_lim) begin
      sat = {1'b1, {(OW-1){1'b0}}};
    end else begin
      sat = x[OW-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    wa <= nega[QW] ? -SW'(signed'({1'b0, xa[QW]})) : SW'(signed'({1'b0, xa[QW]}));
    wb <= negb[QW] ? -SW'(signed'({1'b0, xb[QW]})) : SW'(signed'({1'b0, xb[QW]}));
    nz_t <= nz[QW];
    wa2 <= XW'(wa);
    wb2 <= XW'(wb);
    wc2 <= (XW'(1) <<< FB) - XW'(wa) - XW'(wb);
    nz_u <= nz_t;
    if (nz_u) begin
      bary_a <= sat(wa2);
      bary_b <= sat(wb2);
      bary_c <= sat(wc2);
    end else begin
      bary_a <= '0;
      bary_b <= '0;
      bary_c <= '0;
    end
    valid_res <= nz_u;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      v_t <= 1'b0;
      done <= 1'b0;
    end else begin
      vld <= {vld[QW-1:0], in_valid};
      v_t <= vld[QW];
      done <= v_t;
    end
  end

  a_zero_on_degen: assert property (@(posedge clk) disable iff (rst)
    (done && !valid_res) |-> (bary_a == '0 && bary_b == '0 && bary_c == '0))
    else $error("Degenerate result carries nonzero weights.");
  a_done_from_pipe: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(v_t))
    else $error("Result strobe without a beat in the pipeline.");
  a_sum_one: assert property (@(posedge clk) disable iff (rst)
    v_t |-> (wa2 + wb2 + wc2 == (XW'(1) <<< FB)))
    else $error("Unsaturated weights do not sum to one.");

endmodule

// ----- rtl/core/triangle_barycentric_coords_top.sv -----
`timescale 1ns / 1ps
// A beat goes from start to done through the front pipeline, the queue and
// one divider stage per quotient bit.
// Throughput: one beat per clock; busy stays low since the back never stalls.
// Reset (rst, synchronous) empties the pipeline and queue; no result is lost
// to the receiver, which takes every done beat. Depends on tbc_pkg and submodules.
module triangle_barycentric_coords_top #(
  parameter int COORD_BITS = tbc_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [COORD_BITS-1:0]       v0_x,
  input  logic signed [COORD_BITS-1:0]       v0_y,
  input  logic signed [COORD_BITS-1:0]       v0_z,
  input  logic signed [COORD_BITS-1:0]       v1_x,
  input  logic signed [COORD_BITS-1:0]       v1_y,
  input  logic signed [COORD_BITS-1:0]       v1_z,
  input  logic signed [COORD_BITS-1:0]       v2_x,
  input  logic signed [COORD_BITS-1:0]       v2_y,
  input  logic signed [COORD_BITS-1:0]       v2_z,
  input  logic signed [COORD_BITS-1:0]       p_x,
  input  logic signed [COORD_BITS-1:0]       p_y,
  input  logic signed [COORD_BITS-1:0]       p_z,
  output logic                               done,
  output logic signed [tbc_pkg::OUT_W-1:0]   bary_a,
  output logic signed [tbc_pkg::OUT_W-1:0]   bary_b,
  output logic signed [tbc_pkg::OUT_W-1:0]   bary_c,
  output logic                               valid_res
);

  localparam int DW = COORD_BITS + 1;
  localparam int CW = 2 * DW + 1;
  localparam int PW = 2 * CW + 2;
  localparam int QW = PW + tbc_pkg::FRAC_BITS;
  localparam int FW = 3 + PW + 2 * QW;

  logic accept;
  logic f_valid, q_full, q_valid;
  logic [FW-1:0] f_data, q_data;

  assign accept = start && !busy;
  assign busy = q_full;

  tbc_front #(.CB(COORD_BITS), .FW(FW)) u_front (
    .clk(clk), .rst(rst), .in_valid(accept),
    .v0_x(v0_x), .v0_y(v0_y), .v0_z(v0_z),
    .v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z),
    .v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z),
    .p_x(p_x), .p_y(p_y), .p_z(p_z),
    .out_valid(f_valid), .out_data(f_data)
  );

  tbc_fifo #(.W(FW), .DEPTH(tbc_pkg::QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst(rst), .push(f_valid), .push_data(f_data),
    .full(q_full), .pop_valid(q_valid), .pop_data(q_data)
  );

  tbc_back #(.CB(COORD_BITS), .FW(FW)) u_back (
    .clk(clk), .rst(rst), .in_valid(q_valid), .in_data(q_data),
    .done(done), .bary_a(bary_a), .bary_b(bary_b), .bary_c(bary_c),
    .valid_res(valid_res)
  );

endmodule

// ----- tb/triangle_barycentric_coords_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for triangle_barycentric_coords_top: random and corner triangles,
// with barycentric weights predicted in wide integer math. Depends on tbc_pkg and the RTL.
module triangle_barycentric_coords_top_tb;

  localparam int CB = tbc_pkg::COORD_BITS_DEF;
  localparam int OUT_W = tbc_pkg::OUT_W;
  localparam int FRAC_BITS = tbc_pkg::FRAC_BITS;
  localparam int WD_LIMIT = 2000;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct {
    coord_t c [12];
  } query_t;
  typedef struct {
    logic signed [OUT_W-1:0] a;
    logic signed [OUT_W-1:0] b;
    logic signed [OUT_W-1:0] c;
    logic                    ok;
  } weights_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done, valid_res;
  coord_t crd [12];
  logic signed [OUT_W-1:0] bary_a, bary_b, bary_c;

  query_t   pending_q [$];
  weights_t expected_q [$];
  int       idle_pct = 0;
  int       watchdog = 0;
  int       errors = 0;

  always #6 clk = ~clk;

  triangle_barycentric_coords_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .v0_x(crd[0]), .v0_y(crd[1]), .v0_z(crd[2]),
    .v1_x(crd[3]), .v1_y(crd[4]), .v1_z(crd[5]),
    .v2_x(crd[6]), .v2_y(crd[7]), .v2_z(crd[8]),
    .p_x(crd[9]), .p_y(crd[10]), .p_z(crd[11]),
    .done(done), .bary_a(bary_a), .bary_b(bary_b), .bary_c(bary_c),
    .valid_res(valid_res)
  );

  function automatic logic signed [OUT_W-1:0] clamp32(logic signed [255:0] x);
    if (x > 256'sd2147483647) return 32'h7fffffff;
    if (x < -256'sd2147483648) return 32'h80000000;
    return x[OUT_W-1:0];
  endfunction

  function automatic logic signed [255:0] round_div(logic signed [255:0] num,
                                                    logic signed [255:0] den);
    logic signed [255:0] m;
    logic signed [255:0] q;
    m = (num < 0) ? -num : num;
    q = ((m <<< FRAC_BITS) + (den >>> 1)) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic weights_t barycentric(query_t t);
    logic signed [255:0] v [3][3];
    logic signed [255:0] p [3];
    logic signed [255:0] e1 [3], e2 [3], e4 [3], e5 [3], e3 [3];
    logic signed [255:0] n [3], s0 [3], s1 [3];
    logic signed [255:0] nn, d0, d1, wa, wb, wc;
    weights_t r;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) v[k][i] = t.c[3*k+i];
      p[i] = t.c[9+i];
    end
    for (int i = 0; i < 3; i++) begin
      e1[i] = v[1][i] - v[0][i];
      e2[i] = v[2][i] - v[0][i];
      e3[i] = v[0][i] - p[i];
      e4[i] = v[1][i] - p[i];
      e5[i] = v[2][i] - p[i];
    end
    for (int i = 0; i < 3; i++) begin
      n[i]  = e1[(i+1)%3] * e2[(i+2)%3] - e1[(i+2)%3] * e2[(i+1)%3];
      s0[i] = e4[(i+1)%3] * e5[(i+2)%3] - e4[(i+2)%3] * e5[(i+1)%3];
      s1[i] = e5[(i+1)%3] * e3[(i+2)%3] - e5[(i+2)%3] * e3[(i+1)%3];
    end
    nn = n[0]*n[0] + n[1]*n[1] + n[2]*n[2];
    if (nn == 0) begin
      r = '{a: '0, b: '0, c: '0, ok: 1'b0};
      return r;
    end
    d0 = s0[0]*n[0] + s0[1]*n[1] + s0[2]*n[2];
    d1 = s1[0]*n[0] + s1[1]*n[1] + s1[2]*n[2];
    wa = round_div(d0, nn);
    wb = round_div(d1, nn);
    wc = (256'sd1 <<< FRAC_BITS) - wa - wb;
    r.a = clamp32(wa);
    r.b = clamp32(wb);
    r.c = clamp32(wc);
    r.ok = 1'b1;
    return r;
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 64) - 32);
      2: return ($urandom_range(0, 1) != 0) ? coord_t'(-32768) : coord_t'(32767);
      default: return coord_t'($urandom_range(0, 4000) - 2000);
    endcase
  endfunction

  task automatic add_query(query_t t);
    pending_q.push_back(t);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_q.push_back(barycentric(pending_q.pop_front()));
      end
      if ((!start || !busy) && pending_q.size() > 0 &&
          ($urandom_range(0, 99) >= idle_pct)) begin
        if (start && !busy) begin
          for (int i = 0; i < 12; i++) crd[i] <= pending_q[0].c[i];
          start <= 1'b1;
        end else begin
          for (int i = 0; i < 12; i++) crd[i] <= pending_q[0].c[i];
          start <= 1'b1;
        end
      end else if (!start || !busy) begin
        start <= 1'b0;
        for (int i = 0; i < 12; i++) crd[i] <= coord_t'($urandom);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      weights_t e;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (valid_res !== e.ok) begin
          $error("valid_res expected %0d got %0d", e.ok, valid_res); errors++;
        end
        if (bary_a !== e.a) begin
          $error("bary_a expected %0d got %0d", e.a, bary_a); errors++;
        end
        if (bary_b !== e.b) begin
          $error("bary_b expected %0d got %0d", e.b, bary_b); errors++;
        end
        if (bary_c !== e.c) begin
          $error("bary_c expected %0d got %0d", e.c, bary_c); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog > WD_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    query_t t;
    int mode;
    for (int i = 0; i < 12; i++) crd[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Corner triangles: degenerate, extreme coordinates, point at a vertex and outside.
    foreach (t.c[i]) t.c[i] = '0;
    add_query(t);
    foreach (t.c[i]) t.c[i] = coord_t'(-32768);
    add_query(t);
    foreach (t.c[i]) t.c[i] = coord_t'(i % 2 ? 32767 : -32768);
    add_query(t);
    t.c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0};
    add_query(t);
    t.c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 1, 0};
    add_query(t);
    t.c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, -32768, 32767, 100};
    add_query(t);
    t.c = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, 32767,
            32767, 32767, -32768};
    add_query(t);
    t.c = '{0, 0, 0, 2, 2, 2, 4, 4, 4, 1, 1, 1};
    add_query(t);
    t.c = '{0, 0, 0, 3, 0, 0, 0, 3, 0, 1, 1, 0};
    add_query(t);
    t.c = '{0, 0, 0, 32767, 0, 0, 0, 1, 0, 0, 32767, 0};
    add_query(t);
    for (int k = 0; k < 10; k++) begin
      foreach (t.c[i]) t.c[i] = rand_coord(2);
      add_query(t);
    end

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 49 : (ph == 3) ? 36 : 0;
      for (int k = 0; k < 450; k++) begin
        mode = $urandom_range(0, 5);
        foreach (t.c[i]) t.c[i] = rand_coord(mode > 3 ? 0 : mode);
        if ($urandom_range(0, 19) == 0) begin
          for (int i = 0; i < 3; i++) t.c[6+i] = t.c[3+i];
        end
        add_query(t);
      end
      while (pending_q.size() > 0) @(posedge clk);
    end
    @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
